>>> rtl/reply_container_deframer_macros.svh
// ----------------------------------------------------------------------------
// reply container deframer assertion macros
// concurrent assertion helpers, empty when SYNTHESIS is defined
// ----------------------------------------------------------------------------
`ifndef REPLY_CONTAINER_DEFRAMER_MACROS_SVH
`define REPLY_CONTAINER_DEFRAMER_MACROS_SVH

`ifndef SYNTHESIS
// condition holds at every clock edge out of reset
`define RCD_ASSERT(label, cond) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) \
        else $error("assertion failed");
// antecedent implies consequent in the next cycle
`define RCD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define RCD_ASSERT(label, cond)
`define RCD_ASSERT_NEXT(label, ante, cons)
`endif

`endif

>>> rtl/rcd_pkg.sv
// ----------------------------------------------------------------------------
// rcd_pkg
// shared types and constants of the reply container deframer
// ----------------------------------------------------------------------------
package rcd_pkg;

    localparam int IMAGE_HEADER_BYTES = 13;

    localparam int POS_W = 17;
    localparam int LEN_W = POS_W + 1;
    localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};

    // header byte offsets
    localparam logic [POS_W-1:0] POS_TYPE      = 17'd0;
    localparam logic [POS_W-1:0] POS_LEN_LO    = 17'd1;
    localparam logic [POS_W-1:0] POS_LEN_HI    = 17'd2;
    localparam logic [POS_W-1:0] POS_HDR_CHECK = 17'd3;
    localparam logic [POS_W-1:0] POS_COMMAND   = 17'd4;
    localparam logic [POS_W-1:0] POS_ILEN_LO   = 17'd5;
    localparam logic [POS_W-1:0] POS_ILEN_HI   = 17'd6;
    localparam logic [POS_W-1:0] POS_CMD_BODY  = 17'd7;

    // container modes
    localparam logic [1:0] MODE_COMMAND = 2'd0;
    localparam logic [1:0] MODE_TLS     = 2'd1;
    localparam logic [1:0] MODE_IMAGE   = 2'd2;

    // container type bytes
    localparam logic [7:0] TYPE_COMMAND = 8'hA0;
    localparam logic [7:0] TYPE_TLS     = 8'hB0;
    localparam logic [7:0] TYPE_IMAGE   = 8'hB2;
    localparam logic [7:0] INNER_SUM_OK = 8'hAA;

    // configuration register indexes
    localparam logic CFG_MODE         = 1'b0;
    localparam logic CFG_EXPECTED_CMD = 1'b1;

    // verdict codes
    localparam logic [3:0] VERDICT_OK        = 4'd0;
    localparam logic [3:0] VERDICT_TOO_SHORT = 4'd1;
    localparam logic [3:0] VERDICT_BAD_LEN   = 4'd2;
    localparam logic [3:0] VERDICT_WRONG_TYPE = 4'd3;
    localparam logic [3:0] VERDICT_HDR_SUM   = 4'd4;
    localparam logic [3:0] VERDICT_INNER_LEN = 4'd5;
    localparam logic [3:0] VERDICT_WRONG_CMD = 4'd6;
    localparam logic [3:0] VERDICT_INNER_SUM = 4'd7;
    localparam logic [3:0] VERDICT_NO_IMAGE_HDR = 4'd8;

    // header fields as they stand after the current byte
    typedef struct packed {
        logic [7:0]  type_seen;
        logic [7:0]  header_sum;
        logic [7:0]  header_check;
        logic [15:0] declared_length;
        logic [7:0]  command_seen;
        logic [15:0] inner_length;
        logic [7:0]  inner_sum;
    } hdr_t;

endpackage

>>> rtl/rcd_tracker.sv
// ----------------------------------------------------------------------------
// rcd_tracker
// byte position and captured header fields of the container in flight
// ----------------------------------------------------------------------------
`include "reply_container_deframer_macros.svh"

module rcd_tracker (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        step,
    input  logic [7:0]                  rx_byte,
    input  logic                        last,
    output logic [rcd_pkg::POS_W-1:0]   position,
    output rcd_pkg::hdr_t               hdr
);
    import rcd_pkg::*;

    logic [POS_W-1:0] position_reg;
    logic [POS_W-1:0] position_next;
    hdr_t             hdr_reg;
    hdr_t             hdr_next;

    always_comb begin
        hdr_next = hdr_reg;
        case (position_reg)
            POS_TYPE:      hdr_next.type_seen = rx_byte;
            POS_LEN_LO:    hdr_next.declared_length[7:0] = rx_byte;
            POS_LEN_HI:    hdr_next.declared_length[15:8] = rx_byte;
            POS_HDR_CHECK: hdr_next.header_check = rx_byte;
            POS_COMMAND:   hdr_next.command_seen = rx_byte;
            POS_ILEN_LO:   hdr_next.inner_length[7:0] = rx_byte;
            POS_ILEN_HI:   hdr_next.inner_length[15:8] = rx_byte;
            default: ;
        endcase
        if (position_reg < POS_HDR_CHECK) begin
            hdr_next.header_sum = hdr_reg.header_sum + rx_byte;
        end
        if (position_reg >= POS_COMMAND) begin
            hdr_next.inner_sum = hdr_reg.inner_sum + rx_byte;
        end
    end

    always_comb begin
        if (position_reg == POS_MAX) begin
            position_next = position_reg;
        end else begin
            position_next = position_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            position_reg <= '0;
            hdr_reg      <= '0;
        end else if (step) begin
            if (last) begin
                position_reg <= '0;
                hdr_reg      <= '0;
            end else begin
                position_reg <= position_next;
                hdr_reg      <= hdr_next;
            end
        end
    end

    assign position = position_reg;
    assign hdr      = hdr_next;

    // end of a container starts the next one from offset zero
    `RCD_ASSERT_NEXT(a_clear_on_last, step && last, position_reg == '0 && hdr_reg == '0)
    // inside a container the position only moves forward or stays saturated
    `RCD_ASSERT_NEXT(a_pos_forward, step && !last, position_reg >= $past(position_reg))

endmodule

>>> rtl/rcd_judge.sv
// ----------------------------------------------------------------------------
// rcd_judge
// payload region flag and final verdict for the current byte
// ----------------------------------------------------------------------------
module rcd_judge (
    input  logic [1:0]                  mode,
    input  logic [7:0]                  want_cmd,
    input  logic [rcd_pkg::POS_W-1:0]   position,
    input  rcd_pkg::hdr_t               hdr,
    input  logic                        last,
    output logic                        payload_valid,
    output logic [3:0]                  verdict
);
    import rcd_pkg::*;

    logic [LEN_W-1:0] total_len;
    logic [LEN_W-1:0] decl_total;
    logic [LEN_W-1:0] inner_total;
    logic [POS_W-1:0] decl_end;
    logic [POS_W-1:0] inner_end;
    logic [7:0]       want_type;
    logic [3:0]       outer;
    logic [3:0]       full;

    assign total_len   = {1'b0, position} + 1'b1;
    assign decl_total  = {2'b00, hdr.declared_length} + LEN_W'(4);
    assign inner_total = {2'b00, hdr.inner_length} + LEN_W'(7);
    assign decl_end    = {1'b0, hdr.declared_length} + POS_W'(4);
    assign inner_end   = {1'b0, hdr.inner_length} + POS_W'(6);

    always_comb begin
        case (mode)
            MODE_COMMAND: want_type = TYPE_COMMAND;
            MODE_TLS:     want_type = TYPE_TLS;
            default:      want_type = TYPE_IMAGE;
        endcase
    end

    // checks common to the command, TLS and image modes, in order
    always_comb begin
        if (total_len < LEN_W'(4)) begin
            outer = VERDICT_BAD_LEN;
        end else if (hdr.type_seen != want_type) begin
            outer = VERDICT_WRONG_TYPE;
        end else if (hdr.header_sum != hdr.header_check) begin
            outer = VERDICT_HDR_SUM;
        end else if (decl_total != total_len) begin
            outer = VERDICT_BAD_LEN;
        end else begin
            outer = VERDICT_OK;
        end
    end

    always_comb begin
        case (mode)
            MODE_COMMAND: begin
                if (total_len < LEN_W'(8)) begin
                    full = VERDICT_TOO_SHORT;
                end else if (outer != VERDICT_OK) begin
                    full = outer;
                end else if (hdr.inner_length == '0 || inner_total != total_len) begin
                    full = VERDICT_INNER_LEN;
                end else if (hdr.command_seen != want_cmd) begin
                    full = VERDICT_WRONG_CMD;
                end else if (hdr.inner_sum != INNER_SUM_OK) begin
                    full = VERDICT_INNER_SUM;
                end else begin
                    full = VERDICT_OK;
                end
            end
            MODE_TLS: full = outer;
            MODE_IMAGE: begin
                if (outer != VERDICT_OK) begin
                    full = outer;
                end else if (total_len <= LEN_W'(IMAGE_HEADER_BYTES)) begin
                    full = VERDICT_NO_IMAGE_HDR;
                end else begin
                    full = VERDICT_OK;
                end
            end
            default: begin
                full = (total_len < LEN_W'(4)) ? VERDICT_BAD_LEN : VERDICT_WRONG_TYPE;
            end
        endcase
    end

    always_comb begin
        case (mode)
            MODE_COMMAND: payload_valid = position >= POS_CMD_BODY && position < inner_end;
            MODE_TLS:     payload_valid = position >= POS_COMMAND && position < decl_end;
            MODE_IMAGE:   payload_valid = position >= POS_W'(IMAGE_HEADER_BYTES)
                                          && position < decl_end;
            default:      payload_valid = 1'b0;
        endcase
    end

    assign verdict = last ? full : VERDICT_OK;

endmodule

>>> rtl/reply_container_deframer.sv
// ----------------------------------------------------------------------------
// reply_container_deframer
// byte-wise checker for received reply containers
// ----------------------------------------------------------------------------
// One byte enters per item on the s_ channel, with s_tlast on the last byte of
// a container. Every byte comes back out on the m_ channel unchanged, with
// m_tuser set while it lies in the payload region of the selected mode; the
// flag is given as the byte passes, before the container is known good. On the
// last byte m_tlast is high and m_tdata[11:8] carries the verdict (0 ok,
// 1 too short, 2 bad length, 3 wrong type, 4 header sum, 5 inner length,
// 6 wrong command, 7 inner sum, 8 no image header); on other bytes it is zero.
// The block takes one item every cycle: an input register and a result
// register frame a single pass of header capture and checks, and an accepted
// item moves from the input register to the result register, where it is
// presented on m_; the rate is set only by m_tready. Byte positions saturate
// at 131071, so overlong containers fail the length check. Write
// container_mode (index 0) and the command byte to match (index 1) only while
// no container is in flight.
// ----------------------------------------------------------------------------
`include "reply_container_deframer_macros.svh"

module reply_container_deframer (
    input  logic        aclk,
    input  logic        aresetn,
    // input channel
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] rx_byte
    input  logic        s_tlast,    // final_byte
    // result channel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,    // [7:0] payload_byte, [11:8] verdict, rest zero
    output logic        m_tuser,    // payload_valid
    output logic        m_tlast,    // verdict_ready
    // configuration
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [7:0]  cfg_wdata
);
    import rcd_pkg::*;

    // configuration registers
    logic [1:0] mode_reg;
    logic [7:0] expected_cmd_reg;

    // input register
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;

    // result register
    logic       out_valid_reg;
    logic [7:0] out_byte_reg;
    logic       out_pv_reg;
    logic       out_last_reg;
    logic [3:0] out_verdict_reg;

    logic             advance;
    logic             step;
    logic [POS_W-1:0] position;
    hdr_t             hdr;
    logic             pv_next;
    logic [3:0]       verdict_next;

    // result register frees when empty or taken this cycle
    assign advance  = !out_valid_reg || m_tready;
    // input register moves into the result register
    assign step     = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg         <= MODE_COMMAND;
            expected_cmd_reg <= '0;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_MODE:         mode_reg <= cfg_wdata[1:0];
                CFG_EXPECTED_CMD: expected_cmd_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    // header capture and running sums
    rcd_tracker u_tracker (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .step     (step),
        .rx_byte  (in_byte_reg),
        .last     (in_last_reg),
        .position (position),
        .hdr      (hdr)
    );

    // payload region and verdict
    rcd_judge u_judge (
        .mode          (mode_reg),
        .want_cmd      (expected_cmd_reg),
        .position      (position),
        .hdr           (hdr),
        .last          (in_last_reg),
        .payload_valid (pv_next),
        .verdict       (verdict_next)
    );

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (step) begin
            out_byte_reg    <= in_byte_reg;
            out_pv_reg      <= pv_next;
            out_last_reg    <= in_last_reg;
            out_verdict_reg <= verdict_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0000, out_verdict_reg, out_byte_reg};
    assign m_tuser  = out_pv_reg;
    assign m_tlast  = out_last_reg;

    // a waiting input item is never dropped while the result side stalls
    `RCD_ASSERT_NEXT(a_in_hold, in_valid_reg && !advance, in_valid_reg)
    // a verdict is only reported on the last byte of a container
    `RCD_ASSERT(a_verdict_on_last, !out_valid_reg || out_last_reg || out_verdict_reg == VERDICT_OK)

endmodule
